[rtl/core/dssm_pkg.sv]
// Shared types and codes for the dual stack shared memory unit.
// No dependencies; used by every module under rtl/core.
`default_nettype none

package dssm_pkg;

  // request codes carried in the func field
  localparam logic [2:0] FUNC_PUSH_A = 3'd0;
  localparam logic [2:0] FUNC_POP_A  = 3'd1;
  localparam logic [2:0] FUNC_PUSH_B = 3'd2;
  localparam logic [2:0] FUNC_POP_B  = 3'd3;
  localparam logic [2:0] FUNC_DUMP_A = 3'd4;
  localparam logic [2:0] FUNC_DUMP_B = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] data_out;
    logic [1:0]         status;
    logic               last;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic       push;       // write value on selected stack (never issued when full)
    logic       pop;        // read top of selected stack and drop it
    logic       dump;       // read top of selected stack, start a walk to the bottom
    logic       sel_b;      // 1: stack B, 0: stack A
    logic       rd_next;    // next word of a running dump
    logic       load_code;  // output <= zero data, code, last
    logic [1:0] code;
    logic       load_data;  // output <= read data, ok
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty_a;
    logic empty_b;
    logic out_last;
  } sts_t;

endpackage

`default_nettype wire

[rtl/core/dual_stack_shared_memory_unit.sv]
// Two stacks in one DEPTH-word memory: A grows up from entry 0, B down from the top.
// Push and full/empty status results go straight into the output register; a pop's word
// passes the registered memory read first. One request at a time: no new request is taken
// until the last result (for a dump, its last word) has left the single output register.
// Reset (rst_ni low, async) empties both stacks; memory contents are not cleared.
// Depends on dssm_pkg, dssm_ctrl, dssm_datapath.
`default_nettype none

module dual_stack_shared_memory_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_stall_o,
  input  dssm_pkg::req_t in_i,
  output logic           out_valid_o,
  input  wire            out_stall_i,
  output dssm_pkg::rsp_t out_o
);

  dssm_pkg::cmd_t cmd;
  dssm_pkg::sts_t sts;

  dssm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .func_i      (in_i.func),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dssm_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .value_i (in_i.value),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .rsp_o   (out_o)
  );

endmodule

`default_nettype wire

[rtl/core/dssm_datapath.sv]
// Datapath: shared word memory, stack counters, dump walker and output register.
// Depends on dssm_pkg; driven by dssm_ctrl through cmd_t.
`default_nettype none

module dssm_datapath #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire logic signed [31:0] value_i,
  input  dssm_pkg::cmd_t      cmd_i,
  output dssm_pkg::sts_t      sts_o,
  output dssm_pkg::rsp_t      rsp_o
);

  logic [31:0]     mem_q [DEPTH];
  logic [CW-1:0]   count_a_q, count_a_d;
  logic [CW-1:0]   count_b_q, count_b_d;
  logic [CW-1:0]   remain_q, remain_d;
  logic [AW-1:0]   ptr_q, ptr_d;
  logic            dir_b_q, dir_b_d;
  logic [31:0]     rdata_q;
  dssm_pkg::rsp_t  out_q, out_d;

  logic [CW:0]     sum;
  logic            full;
  logic [CW-1:0]   top_a, top_b;
  logic [AW-1:0]   start_addr, ptr_nxt, rd_addr, wr_addr;
  logic            rd_en, wr_en;

  assign sum   = {1'b0, count_a_q} + {1'b0, count_b_q};
  assign full  = sum >= (CW + 1)'(DEPTH);
  assign top_a = count_a_q - CW'(1);
  assign top_b = CW'(DEPTH) - count_b_q;

  assign start_addr = cmd_i.sel_b ? top_b[AW-1:0] : top_a[AW-1:0];
  assign ptr_nxt    = dir_b_q ? ptr_q + AW'(1) : ptr_q - AW'(1);
  assign rd_en      = cmd_i.pop | cmd_i.dump | cmd_i.rd_next;
  assign rd_addr    = cmd_i.rd_next ? ptr_nxt : start_addr;
  assign wr_en      = cmd_i.push;
  assign wr_addr    = cmd_i.sel_b ? (AW'(DEPTH - 1) - count_b_q[AW-1:0])
                                  : count_a_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    count_a_d = count_a_q;
    count_b_d = count_b_q;
    remain_d  = remain_q;
    ptr_d     = ptr_q;
    dir_b_d   = dir_b_q;
    out_d     = out_q;
    if (cmd_i.push) begin
      if (cmd_i.sel_b) count_b_d = count_b_q + CW'(1);
      else             count_a_d = count_a_q + CW'(1);
    end
    if (cmd_i.pop) begin
      if (cmd_i.sel_b) count_b_d = count_b_q - CW'(1);
      else             count_a_d = count_a_q - CW'(1);
    end
    if (cmd_i.pop || cmd_i.dump) begin
      ptr_d    = start_addr;
      dir_b_d  = cmd_i.sel_b;
      remain_d = cmd_i.pop ? CW'(1) : (cmd_i.sel_b ? count_b_q : count_a_q);
    end
    if (cmd_i.rd_next) begin
      ptr_d    = ptr_nxt;
      remain_d = remain_q - CW'(1);
    end
    if (cmd_i.load_code) begin
      out_d.data_out = '0;
      out_d.status   = cmd_i.code;
      out_d.last     = 1'b1;
    end
    if (cmd_i.load_data) begin
      out_d.data_out = rdata_q;
      out_d.status   = dssm_pkg::ST_OK;
      out_d.last     = (remain_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_a_q <= '0;
      count_b_q <= '0;
    end else begin
      count_a_q <= count_a_d;
      count_b_q <= count_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    remain_q <= remain_d;
    ptr_q    <= ptr_d;
    dir_b_q  <= dir_b_d;
    out_q    <= out_d;
  end

  assign sts_o.full     = full;
  assign sts_o.empty_a  = (count_a_q == '0);
  assign sts_o.empty_b  = (count_b_q == '0);
  assign sts_o.out_last = out_q.last;
  assign rsp_o          = out_q;

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum <= (CW + 1)'(DEPTH))
    else $error("stacks overlap");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> !full)
    else $error("push issued on full memory");

  a_push_a_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push && !cmd_i.sel_b |=> count_a_q == $past(count_a_q) + CW'(1))
    else $error("stack A did not grow on push");

  a_dump_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_next |-> remain_q > CW'(1))
    else $error("dump walked past stack bottom");
`endif

endmodule

`default_nettype wire

[rtl/core/dssm_ctrl.sv]
// Controller: request decode and sequencing of reads, dumps and output handoff.
// Depends on dssm_pkg; commands dssm_datapath through cmd_t.
`default_nettype none

module dssm_ctrl (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  input  wire logic [2:0] func_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  wire            out_stall_i,
  input  dssm_pkg::sts_t sts_i,
  output dssm_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_OUT  = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (func_i)
            dssm_pkg::FUNC_PUSH_A, dssm_pkg::FUNC_PUSH_B: begin
              cmd_o.sel_b     = (func_i == dssm_pkg::FUNC_PUSH_B);
              cmd_o.load_code = 1'b1;
              if (sts_i.full) begin
                cmd_o.code = dssm_pkg::ST_FULL;
              end else begin
                cmd_o.code = dssm_pkg::ST_OK;
                cmd_o.push = 1'b1;
              end
              state_d = S_OUT;
            end
            dssm_pkg::FUNC_POP_A, dssm_pkg::FUNC_DUMP_A: begin
              if (sts_i.empty_a) begin
                cmd_o.load_code = 1'b1;
                cmd_o.code      = dssm_pkg::ST_EMPTY;
                state_d         = S_OUT;
              end else begin
                cmd_o.pop  = (func_i == dssm_pkg::FUNC_POP_A);
                cmd_o.dump = (func_i == dssm_pkg::FUNC_DUMP_A);
                state_d    = S_READ;
              end
            end
            dssm_pkg::FUNC_POP_B, dssm_pkg::FUNC_DUMP_B: begin
              cmd_o.sel_b = 1'b1;
              if (sts_i.empty_b) begin
                cmd_o.load_code = 1'b1;
                cmd_o.code      = dssm_pkg::ST_EMPTY;
                state_d         = S_OUT;
              end else begin
                cmd_o.pop  = (func_i == dssm_pkg::FUNC_POP_B);
                cmd_o.dump = (func_i == dssm_pkg::FUNC_DUMP_B);
                state_d    = S_READ;
              end
            end
            default: ;  // unused code: dropped, no result
          endcase
        end
      end
      S_READ: begin
        cmd_o.load_data = 1'b1;
        state_d         = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          if (sts_i.out_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.rd_next = 1'b1;
            state_d       = S_READ;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for dual_stack_shared_memory_unit (two stacks sharing one memory).
// Drives requests through a queue-fed driver and predicts every result with a shadow copy of
// both stacks. Depends on dssm_pkg and the RTL under rtl/core.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned CYCLE_LIMIT  = 1_500_000;
  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned SQUEEZE_LEN  = 400;
  localparam int unsigned TAIL_CYCLES  = 50;

  // codes the block ignores
  localparam logic [2:0] FUNC_UNUSED_6 = 3'd6;
  localparam logic [2:0] FUNC_UNUSED_7 = 3'd7;

  typedef struct {
    dssm_pkg::req_t req;
    bit   drain;    // wait until every pending result is back before offering
    bit   squeeze;  // start the long output hold when offered
  } stack_req_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic out_stall_i = 1'b0;
  dssm_pkg::req_t in_i = '0;
  logic in_stall_o;
  logic out_valid_o;
  dssm_pkg::rsp_t out_o;

  dual_stack_shared_memory_unit #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Shadow stacks and expected results
  // ---------------------------------------------------------------------------
  logic signed [31:0] shadow_mem [DEPTH];
  int unsigned        depth_a = 0;
  int unsigned        depth_b = 0;
  dssm_pkg::rsp_t     rsp_expected [$];
  stack_req_t         req_pending [$];

  int unsigned errors   = 0;
  int unsigned offered  = 0;
  int unsigned accepted = 0;
  int unsigned cycles   = 0;

  function automatic void push_rsp(logic signed [31:0] d, logic [1:0] s, logic l);
    dssm_pkg::rsp_t e;
    e.data_out = d;
    e.status   = s;
    e.last     = l;
    rsp_expected.push_back(e);
  endfunction

  function automatic void predict_stacks(dssm_pkg::req_t r);
    int unsigned n;
    case (r.func)
      dssm_pkg::FUNC_PUSH_A: begin
        if (depth_a + depth_b >= DEPTH) begin
          push_rsp('0, dssm_pkg::ST_FULL, 1'b1);
        end else begin
          shadow_mem[depth_a] = r.value;
          depth_a++;
          push_rsp('0, dssm_pkg::ST_OK, 1'b1);
        end
      end
      dssm_pkg::FUNC_PUSH_B: begin
        if (depth_a + depth_b >= DEPTH) begin
          push_rsp('0, dssm_pkg::ST_FULL, 1'b1);
        end else begin
          depth_b++;
          shadow_mem[DEPTH - depth_b] = r.value;
          push_rsp('0, dssm_pkg::ST_OK, 1'b1);
        end
      end
      dssm_pkg::FUNC_POP_A: begin
        if (depth_a == 0) begin
          push_rsp('0, dssm_pkg::ST_EMPTY, 1'b1);
        end else begin
          depth_a--;
          push_rsp(shadow_mem[depth_a], dssm_pkg::ST_OK, 1'b1);
        end
      end
      dssm_pkg::FUNC_POP_B: begin
        if (depth_b == 0) begin
          push_rsp('0, dssm_pkg::ST_EMPTY, 1'b1);
        end else begin
          push_rsp(shadow_mem[DEPTH - depth_b], dssm_pkg::ST_OK, 1'b1);
          depth_b--;
        end
      end
      dssm_pkg::FUNC_DUMP_A: begin
        n = depth_a;
        if (n == 0) push_rsp('0, dssm_pkg::ST_EMPTY, 1'b1);
        for (int k = 0; k < n; k++) begin
          push_rsp(shadow_mem[n - 1 - k], dssm_pkg::ST_OK, k == n - 1);
        end
      end
      dssm_pkg::FUNC_DUMP_B: begin
        n = depth_b;
        if (n == 0) push_rsp('0, dssm_pkg::ST_EMPTY, 1'b1);
        for (int k = 0; k < n; k++) begin
          push_rsp(shadow_mem[DEPTH - n + k], dssm_pkg::ST_OK, k == n - 1);
        end
      end
      default: ;  // unused code: no result, no state change
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void add_req(logic [2:0] f, logic [31:0] v, bit dr, bit sq);
    stack_req_t s;
    s.req.func  = f;
    s.req.value = v;
    s.drain     = dr;
    s.squeeze   = sq;
    req_pending.push_back(s);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // mostly short idles, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 8);
    return $urandom_range(20, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: changes inputs at the falling edge, holds a transaction until accepted
  // ---------------------------------------------------------------------------
  stack_req_t  drv_cur;
  int unsigned drv_gap   = 0;
  bit          drv_calm  = 1'b0;
  logic        squeeze_go = 1'b0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (offered == accepted) begin
      if ($urandom_range(0, 63) == 0) drv_calm = !drv_calm;
      if (drv_gap > 0) begin
        drv_gap--;
        in_valid_i <= 1'b0;
      end else if (req_pending.size() > 0 &&
                   (!req_pending[0].drain || rsp_expected.size() == 0)) begin
        drv_cur = req_pending.pop_front();
        in_i       <= drv_cur.req;
        in_valid_i <= 1'b1;
        offered++;
        if (drv_cur.squeeze) squeeze_go <= 1'b1;
        drv_gap = drv_calm ? 0 : pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output stall generator, including one long hold while input keeps coming
  // ---------------------------------------------------------------------------
  int unsigned hold_left    = 0;
  bit          squeeze_done = 1'b0;
  bit          rcv_calm     = 1'b0;
  int unsigned rcv_gap;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (squeeze_go && !squeeze_done) begin
      squeeze_done = 1'b1;
      hold_left    = SQUEEZE_LEN;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if ($urandom_range(0, 63) == 0) rcv_calm = !rcv_calm;
      rcv_gap = rcv_calm ? 0 : pick_gap();
      if (rcv_gap > 0) begin
        hold_left = rcv_gap - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: both handshakes sampled at the rising edge
  // ---------------------------------------------------------------------------
  dssm_pkg::rsp_t mon_exp;

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (rsp_expected.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: expected none, actual %0h/%0d/%0d",
                   $time, out_o.data_out, out_o.status, out_o.last);
        end else begin
          mon_exp = rsp_expected.pop_front();
          check_field("data_out", mon_exp.data_out, out_o.data_out);
          check_field("status", 32'(mon_exp.status), 32'(out_o.status));
          check_field("last", 32'(mon_exp.last), 32'(out_o.last));
        end
      end
      // result of an earlier transaction is checked first, then the new one is predicted
      if (in_valid_i && !in_stall_o) begin
        predict_stacks(in_i);
        accepted++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned counted;
    int unsigned mode;
    int unsigned len;
    int unsigned r;
    bit          sel_b;
    logic [2:0]  f;

    // empty stacks and ignored codes
    add_req(dssm_pkg::FUNC_POP_A, 32'h1234_5678, 1'b0, 1'b0);
    add_req(dssm_pkg::FUNC_POP_B, 32'h8765_4321, 1'b0, 1'b0);
    add_req(dssm_pkg::FUNC_DUMP_A, 32'hFFFF_FFFF, 1'b0, 1'b0);
    add_req(dssm_pkg::FUNC_DUMP_B, 32'h0000_0000, 1'b0, 1'b0);
    add_req(FUNC_UNUSED_6, 32'hDEAD_BEEF, 1'b0, 1'b0);
    add_req(FUNC_UNUSED_7, 32'h5555_5555, 1'b0, 1'b0);
    // fill the memory until the stacks meet, extremes first
    add_req(dssm_pkg::FUNC_PUSH_A, 32'h7FFF_FFFF, 1'b0, 1'b0);
    add_req(dssm_pkg::FUNC_PUSH_B, 32'h8000_0000, 1'b0, 1'b0);
    add_req(dssm_pkg::FUNC_PUSH_A, 32'h0000_0000, 1'b0, 1'b0);
    add_req(dssm_pkg::FUNC_PUSH_B, 32'hFFFF_FFFF, 1'b0, 1'b0);
    for (int i = 0; i < DEPTH - 4; i++) begin
      add_req((i % 3 == 2) ? dssm_pkg::FUNC_PUSH_B : dssm_pkg::FUNC_PUSH_A,
              (i % 2) ? 32'hAAAA_AAAA : 32'h5555_5555, 1'b0, 1'b0);
    end
    // both pushes refused when full, then read back through dump and pop
    add_req(dssm_pkg::FUNC_PUSH_A, 32'h0BAD_F00D, 1'b0, 1'b0);
    add_req(dssm_pkg::FUNC_PUSH_B, 32'hF00D_0BAD, 1'b0, 1'b0);
    add_req(dssm_pkg::FUNC_DUMP_A, 32'h0000_0000, 1'b0, 1'b0);
    add_req(dssm_pkg::FUNC_DUMP_B, 32'h0000_0000, 1'b0, 1'b0);
    add_req(dssm_pkg::FUNC_POP_A, 32'h0000_0000, 1'b0, 1'b0);
    add_req(dssm_pkg::FUNC_POP_B, 32'h0000_0000, 1'b0, 1'b0);

    // random episodes biased toward filling, draining or a mix
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 2);
      len  = $urandom_range(4, 30);
      for (int j = 0; j < len && counted < RANDOM_ITEMS; j++) begin
        r     = $urandom_range(0, 99);
        sel_b = $urandom_range(0, 1);
        if (r < 3) begin
          f = sel_b ? FUNC_UNUSED_7 : FUNC_UNUSED_6;
        end else if (r < 13) begin
          f = sel_b ? dssm_pkg::FUNC_DUMP_B : dssm_pkg::FUNC_DUMP_A;
        end else if ((mode == 0 && r < 80) || (mode == 1 && r < 30) ||
                     (mode == 2 && r < 56)) begin
          f = sel_b ? dssm_pkg::FUNC_PUSH_B : dssm_pkg::FUNC_PUSH_A;
        end else begin
          f = sel_b ? dssm_pkg::FUNC_POP_B : dssm_pkg::FUNC_POP_A;
        end
        add_req(f, rand_word(), counted == 0 || $urandom_range(0, 99) == 0,
                counted == 150);
        if (f != FUNC_UNUSED_6 && f != FUNC_UNUSED_7) counted++;
      end
    end

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (req_pending.size() != 0 || offered != accepted || rsp_expected.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
